// ----- hdl/msic_pkg.sv -----
// ----------------------------------------------------------------------------
// msic_pkg: shared types and constants of the integral speed controller
// Field widths, register indexes, reset values and request/result structs.
// ----------------------------------------------------------------------------
package msic_pkg;

	localparam int SPEED_W   = 28;
	localparam int DUTY_W    = 16;
	localparam int TARGET_W  = 12;
	localparam int INCR_W    = 8;
	localparam int TACH_W    = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = SPEED_W;
	localparam int SUM_W     = SPEED_W + 2;

	localparam int PERIOD_WIDTH_DEF = 24;

	localparam logic [SPEED_W-1:0]  SPEED_SCALE_RST = SPEED_W'(200000000);
	localparam logic [DUTY_W-1:0]   DUTY_FLOOR_RST  = DUTY_W'(1500);
	localparam logic [DUTY_W-1:0]   DUTY_CEIL_RST   = DUTY_W'(3500);
	localparam logic [TARGET_W-1:0] TARGET_MIN_RST  = TARGET_W'(100);
	localparam logic [TARGET_W-1:0] TARGET_MAX_RST  = TARGET_W'(600);
	localparam logic [INCR_W-1:0]   TARGET_INC_RST  = INCR_W'(50);
	localparam logic [DUTY_W-1:0]   DUTY_RST        = DUTY_W'(3000);
	localparam logic [TARGET_W-1:0] TARGET_RST      = TARGET_W'(300);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_SCALE  = 3'd0,
		REG_DUTY_FLOOR   = 3'd1,
		REG_DUTY_CEILING = 3'd2,
		REG_TARGET_MIN   = 3'd3,
		REG_TARGET_MAX   = 3'd4,
		REG_TARGET_INC   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [TACH_W-1:0] tach_period;
		logic              raise_request;
		logic              lower_request;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0]   duty_value;
		logic                duty_changed;
		logic [SPEED_W-1:0]  measured_speed;
		logic [TARGET_W-1:0] speed_target;
		logic                period_zero;
	} out_item_t;

endpackage

// ----- hdl/motor_speed_integral_controller.sv -----
// ----------------------------------------------------------------------------
// motor_speed_integral_controller: integral speed controller, one tick per request
// Speed from tachometer period by division, target stepping, windowed duty update.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | in_data   (in_item_t)
//  out     | output    | out_valid/out_stall | out_data  (out_item_t)
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  A request is not followed by another until it has passed the radix-2 divider,
//  one quotient bit per cycle, and the update step.
//  in_stall is high from acceptance until the result is written to the output register.
//  A result waiting under out_stall holds the update step until the register frees.
//  Reset sets config registers, duty (3000) and target (300) to their defaults.
//  cfg_ready is always high.
module motor_speed_integral_controller import msic_pkg::*; #(
	parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t              state_q;
	logic [SPEED_W-1:0]  scale_q;
	logic [DUTY_W-1:0]   floor_q;
	logic [DUTY_W-1:0]   ceil_q;
	logic [TARGET_W-1:0] tmin_q;
	logic [TARGET_W-1:0] tmax_q;
	logic [INCR_W-1:0]   incr_q;
	logic [DUTY_W-1:0]   duty_q;
	logic [TARGET_W-1:0] target_q;
	logic                raise_q;
	logic                lower_q;
	logic                zero_q;
	logic                out_valid_q;
	out_item_t           out_data_q;

	logic [PERIOD_WIDTH-1:0] period;
	logic                    in_acc;
	logic                    div_done;
	logic [SPEED_W-1:0]      div_quot;
	logic [SPEED_W-1:0]      speed;
	logic [TARGET_W:0]       tgt_up;
	logic [TARGET_W-1:0]     tgt_next;
	logic signed [SUM_W-1:0] sum;
	logic                    accept_duty;
	logic                    out_free;

	if (PERIOD_WIDTH <= TACH_W) begin : g_trim
		assign period = in_data.tach_period[PERIOD_WIDTH-1:0];
	end else begin : g_ext
		assign period = {{(PERIOD_WIDTH-TACH_W){1'b0}}, in_data.tach_period};
	end

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	msic_divider #(
		.PERIOD_W(PERIOD_WIDTH)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc),
		.dividend(scale_q),
		.divisor (period),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_comb begin
		speed  = zero_q ? {SPEED_W{1'b1}} : div_quot;
		tgt_up = {1'b0, target_q} + (TARGET_W+1)'(incr_q);
		tgt_next = target_q;
		priority if (raise_q) begin
			if (target_q < tmax_q)
				tgt_next = tgt_up[TARGET_W] ? {TARGET_W{1'b1}} : tgt_up[TARGET_W-1:0];
		end else if (lower_q) begin
			if (target_q > tmin_q)
				tgt_next = (target_q > TARGET_W'(incr_q))
				         ? target_q - TARGET_W'(incr_q) : '0;
		end else begin
			tgt_next = target_q;
		end
		sum = $signed(SUM_W'(duty_q)) + $signed(SUM_W'(target_q)) - $signed(SUM_W'(speed));
		accept_duty = (sum > $signed(SUM_W'(floor_q))) && (sum < $signed(SUM_W'(ceil_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SPEED_SCALE_RST;
			floor_q <= DUTY_FLOOR_RST;
			ceil_q  <= DUTY_CEIL_RST;
			tmin_q  <= TARGET_MIN_RST;
			tmax_q  <= TARGET_MAX_RST;
			incr_q  <= TARGET_INC_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SPEED_SCALE:  scale_q <= cfg_data[SPEED_W-1:0];
				REG_DUTY_FLOOR:   floor_q <= cfg_data[DUTY_W-1:0];
				REG_DUTY_CEILING: ceil_q  <= cfg_data[DUTY_W-1:0];
				REG_TARGET_MIN:   tmin_q  <= cfg_data[TARGET_W-1:0];
				REG_TARGET_MAX:   tmax_q  <= cfg_data[TARGET_W-1:0];
				REG_TARGET_INC:   incr_q  <= cfg_data[INCR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			duty_q      <= DUTY_RST;
			target_q    <= TARGET_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_UPD && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (out_free) begin
						target_q    <= tgt_next;
						if (accept_duty)
							duty_q <= sum[DUTY_W-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			raise_q <= in_data.raise_request;
			lower_q <= in_data.lower_request;
			zero_q  <= (period == '0);
		end
		if (state_q == ST_UPD && out_free) begin
			out_data_q.duty_value     <= accept_duty ? sum[DUTY_W-1:0] : duty_q;
			out_data_q.duty_changed   <= accept_duty;
			out_data_q.measured_speed <= speed;
			out_data_q.speed_target   <= tgt_next;
			out_data_q.period_zero    <= zero_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- hdl/msic_divider.sv -----
// ----------------------------------------------------------------------------
// msic_divider: radix-2 restoring divider
// One quotient bit per cycle; quotient stays valid until the next start.
// ----------------------------------------------------------------------------
module msic_divider import msic_pkg::*; #(
	parameter int PERIOD_W = PERIOD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SPEED_W-1:0]  dividend,
	input  logic [PERIOD_W-1:0] divisor,
	output logic                done,
	output logic [SPEED_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(SPEED_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SPEED_W-1:0]  num_q;
	logic [PERIOD_W-1:0] den_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W:0]   rem_shift;
	logic [PERIOD_W:0]   den_ext;
	logic [PERIOD_W:0]   rem_diff;
	logic                ge;

	always_comb begin
		rem_shift = {rem_q, num_q[SPEED_W-1]};
		den_ext   = {1'b0, den_q};
		ge        = rem_shift >= den_ext;
		rem_diff  = rem_shift - den_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SPEED_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_diff[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
			num_q <= {num_q[SPEED_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ----- hdl/msic_checker.sv -----
// ----------------------------------------------------------------------------
// msic_checker: port-level checks of the integral speed controller
// Handshake hold, busy after request, result timing and zero-period saturation.
// ----------------------------------------------------------------------------
module msic_checker import msic_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while a request is in progress");

	a_free_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("new result while block still busy");

	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.period_zero |-> out_data.measured_speed == {SPEED_W{1'b1}})
		else $error("zero period did not saturate speed");

endmodule

bind motor_speed_integral_controller msic_checker u_msic_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);

// ----- dv/msic_tick_checker.sv -----
// ----------------------------------------------------------------------------
// msic_tick_checker: result predictor and scoreboard for the speed controller
// Watches the config, request and result channels. Each accepted request is
// run through an internal copy of the control law: speed from the period,
// the error against the old target, the button step of the target and the
// windowed duty update. The predicted result is queued, and each accepted
// result is compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module msic_tick_checker import msic_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int                   fail_count,
	output int                   pending
);

	logic [SPEED_W-1:0]  scale_cfg;
	logic [DUTY_W-1:0]   floor_cfg;
	logic [DUTY_W-1:0]   ceil_cfg;
	logic [TARGET_W-1:0] tmin_cfg;
	logic [TARGET_W-1:0] tmax_cfg;
	logic [INCR_W-1:0]   step_cfg;
	logic [DUTY_W-1:0]   duty_now;
	logic [TARGET_W-1:0] target_now;
	out_item_t           tick_results[$];
	int                  misses;

	function automatic out_item_t controller_tick(in_item_t req);
		out_item_t          res;
		logic [SPEED_W-1:0] speed;
		longint             err;
		longint             sum;
		int unsigned        stepped;
		res = '0;
		res.period_zero = (req.tach_period == '0);
		if (res.period_zero)
			speed = '1;
		else
			speed = SPEED_W'(32'(scale_cfg) / 32'(req.tach_period));
		err = longint'(target_now) - longint'(speed);
		if (req.raise_request) begin
			if (target_now < tmax_cfg) begin
				stepped = 32'(target_now) + 32'(step_cfg);
				target_now = (stepped > 32'hFFF) ? '1 : TARGET_W'(stepped);
			end
		end else if (req.lower_request) begin
			if (target_now > tmin_cfg)
				target_now = (32'(target_now) > 32'(step_cfg)) ?
					TARGET_W'(32'(target_now) - 32'(step_cfg)) : '0;
		end
		sum = longint'(duty_now) + err;
		if (sum > longint'(floor_cfg) && sum < longint'(ceil_cfg)) begin
			duty_now = DUTY_W'(sum);
			res.duty_changed = 1'b1;
		end
		res.duty_value = duty_now;
		res.measured_speed = speed;
		res.speed_target = target_now;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_res;
		if (!arst_n) begin
			scale_cfg = SPEED_SCALE_RST;
			floor_cfg = DUTY_FLOOR_RST;
			ceil_cfg = DUTY_CEIL_RST;
			tmin_cfg = TARGET_MIN_RST;
			tmax_cfg = TARGET_MAX_RST;
			step_cfg = TARGET_INC_RST;
			duty_now = DUTY_RST;
			target_now = TARGET_RST;
			misses = 0;
			tick_results.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
				REG_SPEED_SCALE:  scale_cfg = cfg_data;
				REG_DUTY_FLOOR:   floor_cfg = cfg_data[DUTY_W-1:0];
				REG_DUTY_CEILING: ceil_cfg = cfg_data[DUTY_W-1:0];
				REG_TARGET_MIN:   tmin_cfg = cfg_data[TARGET_W-1:0];
				REG_TARGET_MAX:   tmax_cfg = cfg_data[TARGET_W-1:0];
				REG_TARGET_INC:   step_cfg = cfg_data[INCR_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				tick_results.push_back(controller_tick(in_data));
			if (out_valid && !out_stall) begin
				if (tick_results.size() == 0) begin
					misses++;
					if (misses <= 10)
						$display("unexpected result: duty=%0d speed=%0d target=%0d",
							out_data.duty_value, out_data.measured_speed,
							out_data.speed_target);
				end else begin
					exp_res = tick_results.pop_front();
					if (out_data.duty_value !== exp_res.duty_value ||
					    out_data.duty_changed !== exp_res.duty_changed ||
					    out_data.measured_speed !== exp_res.measured_speed ||
					    out_data.speed_target !== exp_res.speed_target ||
					    out_data.period_zero !== exp_res.period_zero) begin
						misses++;
						if (misses <= 10)
							$display({"result mismatch: expected duty=%0d chg=%0b speed=%0d ",
								"target=%0d zero=%0b, got duty=%0d chg=%0b speed=%0d ",
								"target=%0d zero=%0b"},
								exp_res.duty_value, exp_res.duty_changed,
								exp_res.measured_speed, exp_res.speed_target,
								exp_res.period_zero, out_data.duty_value,
								out_data.duty_changed, out_data.measured_speed,
								out_data.speed_target, out_data.period_zero);
					end
				end
			end
			fail_count <= misses;
			pending <= tick_results.size();
		end
	end

endmodule

// ----- dv/tb_motor_speed_integral_controller.sv -----
// ----------------------------------------------------------------------------
// tb_motor_speed_integral_controller: testbench top for the speed controller
// Drives control ticks, config writes and result back-pressure. A directed
// pass covers zero and extreme periods, both buttons, target limits and an
// empty duty window; random phases then sweep config settings with ticks
// shaped around plausible speeds. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_motor_speed_integral_controller;
	import msic_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	int                   fail_count;
	int                   pending;

	logic                 calm = 1'b0;
	logic                 hold_trigger = 1'b0;
	logic                 hold_seen = 1'b0;
	int                   hold_left = 0;
	logic [SPEED_W-1:0]   scale_set = SPEED_SCALE_RST;

	always #10 clk = ~clk;

	motor_speed_integral_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	msic_tick_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// hold off results for a long stretch on request, else stall at random unless calm
	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 9);
		end
	end

	function automatic in_item_t make_tick(logic [TACH_W-1:0] per, logic up, logic down);
		in_item_t t;
		t.tach_period = per;
		t.raise_request = up;
		t.lower_request = down;
		return t;
	endfunction

	function automatic in_item_t random_tick(int unsigned rp, int unsigned lp);
		int unsigned sel;
		int unsigned spd;
		int unsigned per;
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			per = $urandom_range(0, 24'hFFFFFF);
		end else if (sel < 13) begin
			per = 0;
		end else if (sel < 16) begin
			per = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 1;
		end else begin
			spd = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 900);
			per = 32'(scale_set) / spd;
			if (per == 0)
				per = 1;
			else if (per > 24'hFFFFFF)
				per = 24'hFFFFFF;
		end
		return make_tick(TACH_W'(per), $urandom_range(0, 99) < rp, $urandom_range(0, 99) < lp);
	endfunction

	task automatic send_tick(input in_item_t item);
		while (!calm && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
	endtask

	// hold requests until every expected result is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SPEED_SCALE)
			scale_set = val;
	endtask

	task automatic load_settings(input logic [SPEED_W-1:0] scale, input logic [DUTY_W-1:0] lo,
			input logic [DUTY_W-1:0] hi, input logic [TARGET_W-1:0] tmin,
			input logic [TARGET_W-1:0] tmax, input logic [INCR_W-1:0] inc);
		drain();
		write_reg(REG_SPEED_SCALE, scale);
		write_reg(REG_DUTY_FLOOR, CFG_DAT_W'(lo));
		write_reg(REG_DUTY_CEILING, CFG_DAT_W'(hi));
		write_reg(REG_TARGET_MIN, CFG_DAT_W'(tmin));
		write_reg(REG_TARGET_MAX, CFG_DAT_W'(tmax));
		write_reg(REG_TARGET_INC, CFG_DAT_W'(inc));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned rp;
		int unsigned lp;
		int unsigned lo;
		int unsigned tmin;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: zero and extreme periods, both buttons, raise up to the maximum
		send_tick(make_tick(24'd0, 1'b0, 1'b0));
		send_tick(make_tick(24'hFFFFFF, 1'b1, 1'b0));
		send_tick(make_tick(24'd1, 1'b0, 1'b1));
		send_tick(make_tick(24'd666666, 1'b1, 1'b1));
		repeat (6) send_tick(make_tick(24'd400000, 1'b1, 1'b0));

		// wide window, big step: lower through zero and stay there
		load_settings('1, '0, '1, '0, '1, '1);
		repeat (4) send_tick(make_tick(24'hFFFFFF, 1'b0, 1'b1));
		send_tick(make_tick(24'd0, 1'b0, 1'b0));
		send_tick(make_tick(24'd1, 1'b1, 1'b0));

		// floor equal to ceiling: duty never moves
		load_settings(SPEED_W'(1), DUTY_W'(3000), DUTY_W'(3000), TARGET_MIN_RST,
			TARGET_MAX_RST, TARGET_INC_RST);
		send_tick(make_tick(24'hFFFFFF, 1'b1, 1'b0));
		send_tick(make_tick(24'd1, 1'b0, 1'b1));

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
			0: load_settings(SPEED_SCALE_RST, DUTY_FLOOR_RST, DUTY_CEIL_RST,
				TARGET_MIN_RST, TARGET_MAX_RST, TARGET_INC_RST);
			2: load_settings('1, '0, '1, '0, '1, '1);
			4: load_settings(SPEED_W'(1), '1, '0, '1, '0, '0);
			default: begin
				lo = $urandom_range(0, 3000);
				tmin = $urandom_range(0, 1000);
				load_settings(SPEED_W'($urandom_range(1000000, 28'hFFFFFFF)), DUTY_W'(lo),
					DUTY_W'(lo + $urandom_range(500, 4000)), TARGET_W'(tmin),
					TARGET_W'(tmin + $urandom_range(0, 2000)),
					INCR_W'($urandom_range(1, 255)));
			end
			endcase
			calm <= (ph == 3);
			rp = (ph == 2) ? 70 : $urandom_range(10, 60);
			lp = $urandom_range(10, 60);
			for (int n = 0; n < 80; n++) begin
				if (ph == 1 && n == 10)
					hold_trigger <= ~hold_trigger;
				if (ph == 5 && n == 40)
					drain();
				send_tick(random_tick(rp, lp));
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[motor_speed_integral_controller] OK");
		else
			$display("[motor_speed_integral_controller] ERROR");
		$finish;
	end

	initial begin
		#10000000;
		$display("[motor_speed_integral_controller] ERROR");
		$finish;
	end

endmodule
